/* rtl/core/quadrature_position_pid_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the quadrature position controller
// Shared property forms used by the checker. Every macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_POSITION_PID_ASSERT_SVH
`define QUADRATURE_POSITION_PID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadrature_position_pid: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define QPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadrature_position_pid: next-cycle property failed");

`endif

/* rtl/core/qpp_pkg.sv */
// ---------------------------------------------------------------------------
// qpp_pkg
// Constants, codes and beat types of the quadrature position controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qpp_pkg;

    // Sizing of the counters and the integrator.
    localparam int NUM_MOTORS     = 4;
    localparam int COUNT_WIDTH    = 16;
    localparam int INTEGRAL_WIDTH = 32;

    // Fixed field widths.
    localparam int GAIN_W      = 16;
    localparam int OFFSET_W    = 16;
    localparam int POS_W       = 16;
    localparam int DRIVE_W     = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_BITS   = 8;
    localparam int DRIVE_LIMIT = 255;

    // Derived arithmetic widths.
    localparam int ERR_W      = COUNT_WIDTH + 1;
    localparam int DERIV_W    = ERR_W + 1;
    localparam int ISUM_W     = ((INTEGRAL_WIDTH > ERR_W) ? INTEGRAL_WIDTH : ERR_W) + 1;
    localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W   = GAIN_W + 1 + INTEGRAL_WIDTH;
    localparam int PROD_D_W   = GAIN_W + 1 + DERIV_W;
    localparam int PROD_MAX_W = (PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W;
    localparam int SUM_W      = PROD_MAX_W + 2;

    // Gain values after reset (unsigned Q8.8).
    localparam logic [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(26);
    localparam logic [GAIN_W-1:0] GAIN_I_RESET = GAIN_W'(3);
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = GAIN_W'(13);

    // Request codes.
    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_MOVE = 2'd2;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D = CFG_INDEX_W'(2);

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [1:0]                 motor_index;
        logic                       edge_channel;
        logic                       level_a;
        logic                       level_b;
        logic signed [OFFSET_W-1:0] target_offset;
    } req_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      drive_valid;
        logic signed [POS_W-1:0]   position;
    } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/quadrature_position_pid.sv */
// ---------------------------------------------------------------------------
// quadrature_position_pid
// Four quadrature counters and a PID position loop on motor 0.
// ---------------------------------------------------------------------------
// Usage. Request beats arrive on req with req_valid and are taken at a rising
// edge where req_valid is high and req_stall is low. Each request is an
// encoder edge, a control tick or a move command; it yields exactly one
// response beat on rsp, offered with rsp_valid and taken when rsp_stall is
// low. The response carries motor 0's count after the request and the drive
// value; drive_valid is high only for a control tick, and other beats repeat
// the last drive. Gains are written on the cfg channel (cfg_ready is always
// high) and must only be changed while no request is in flight.
// Timing. A new request can be taken in every cycle while req_stall is low.
// The rate is set by the state update stage, where the counters, the target,
// the integral and the last error are all updated together. Four register
// stages sit in line; a stage moves on whenever the one after it is empty
// or moving, so bubbles close up and requests keep being taken while a
// response waits.
// Reset clears the pipeline, every counter, the target, the integral, the
// last error and the last drive, and restores the default gains. A stall on
// rsp holds the response and backs the pipeline up towards req_stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quadrature_position_pid (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    req_valid,
    output logic                                   req_stall,
    input  wire  qpp_pkg::req_t                    req,
    output logic                                   rsp_valid,
    input  wire                                    rsp_stall,
    output qpp_pkg::rsp_t                          rsp,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [qpp_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire  [qpp_pkg::GAIN_W-1:0]             cfg_data
);

    localparam int CW = qpp_pkg::COUNT_WIDTH;
    localparam int IW = qpp_pkg::INTEGRAL_WIDTH;

    localparam logic signed [qpp_pkg::SUM_W-1:0] DRIVE_HI =
        qpp_pkg::SUM_W'(qpp_pkg::DRIVE_LIMIT);
    localparam logic signed [qpp_pkg::SUM_W-1:0] DRIVE_LO = -DRIVE_HI;

    // Gain registers.
    logic [qpp_pkg::GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;

    // Controller state.
    logic [CW-1:0]                     enc_reg [qpp_pkg::NUM_MOTORS];
    logic [CW-1:0]                     enc_next [qpp_pkg::NUM_MOTORS];
    logic [CW-1:0]                     target_reg, target_next;
    logic signed [IW-1:0]              integral_reg, integral_next;
    logic signed [qpp_pkg::ERR_W-1:0]  last_err_reg, last_err_next;
    logic signed [qpp_pkg::DRIVE_W-1:0] last_drive_reg, last_drive_next;

    // Stage 1: request register.
    logic          s1_valid_reg;
    qpp_pkg::req_t s1_req_reg;

    // Stage 2: error terms computed for the request in stage 1.
    logic                                s2_valid_reg;
    logic                                s2_tick_reg;
    logic [CW-1:0]                       s2_pos_reg;
    logic signed [qpp_pkg::ERR_W-1:0]    s2_err_reg;
    logic signed [IW-1:0]                s2_integ_reg;
    logic signed [qpp_pkg::DERIV_W-1:0]  s2_deriv_reg;

    // Stage 3: gain products.
    logic                                s3_valid_reg;
    logic                                s3_tick_reg;
    logic [CW-1:0]                       s3_pos_reg;
    logic signed [qpp_pkg::PROD_P_W-1:0] s3_prod_p_reg, s3_prod_p_next;
    logic signed [qpp_pkg::PROD_I_W-1:0] s3_prod_i_reg, s3_prod_i_next;
    logic signed [qpp_pkg::PROD_D_W-1:0] s3_prod_d_reg, s3_prod_d_next;

    // Output register.
    logic          rsp_valid_reg;
    qpp_pkg::rsp_t rsp_reg, rsp_next;

    // Flow control: a stage may load when it is empty or its beat moves on.
    logic out_free, s3_free, s2_free, s1_free;
    logic s1_move;

    // Stage 2 combinational terms.
    logic                                up;
    logic signed [qpp_pkg::ERR_W-1:0]    err;
    logic signed [qpp_pkg::ISUM_W-1:0]   isum;
    logic                                isum_fits;
    logic signed [IW-1:0]                integ_sat;
    logic signed [qpp_pkg::DERIV_W-1:0]  deriv;

    // Output stage combinational terms.
    logic signed [qpp_pkg::SUM_W-1:0]    sum;
    logic signed [qpp_pkg::SUM_W-1:0]    quot_floor;
    logic signed [qpp_pkg::SUM_W-1:0]    quot;
    logic                                round_up;
    logic signed [qpp_pkg::DRIVE_W-1:0]  drive_clamped;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign s3_free   = !s3_valid_reg || out_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign s1_move   = s1_valid_reg && s2_free;

    assign req_stall = !s1_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // State update for the request in stage 1. The error is the exact signed
    // difference of target and count, one bit wider than a count.
    always_comb
    begin
        up        = s1_req_reg.edge_channel ? (s1_req_reg.level_a != s1_req_reg.level_b)
                                            : (s1_req_reg.level_a == s1_req_reg.level_b);
        err       = $signed({target_reg[CW-1], target_reg}) -
                    $signed({enc_reg[0][CW-1], enc_reg[0]});
        isum      = qpp_pkg::ISUM_W'(integral_reg) + qpp_pkg::ISUM_W'(err);
        isum_fits = (&isum[qpp_pkg::ISUM_W-1:IW-1]) || !(|isum[qpp_pkg::ISUM_W-1:IW-1]);
        if (isum_fits)
        begin
            integ_sat = isum[IW-1:0];
        end
        else if (isum[qpp_pkg::ISUM_W-1])
        begin
            integ_sat = {1'b1, {(IW-1){1'b0}}};
        end
        else
        begin
            integ_sat = {1'b0, {(IW-1){1'b1}}};
        end
        deriv = qpp_pkg::DERIV_W'(err) - qpp_pkg::DERIV_W'(last_err_reg);

        for (int m = 0; m < qpp_pkg::NUM_MOTORS; m++)
        begin
            enc_next[m] = enc_reg[m];
        end
        target_next   = target_reg;
        integral_next = integral_reg;
        last_err_next = last_err_reg;

        case (s1_req_reg.req_type)
            qpp_pkg::REQ_EDGE:
            begin
                for (int m = 0; m < qpp_pkg::NUM_MOTORS; m++)
                begin
                    if (32'(s1_req_reg.motor_index) == m)
                    begin
                        enc_next[m] = up ? enc_reg[m] + CW'(1) : enc_reg[m] - CW'(1);
                    end
                end
            end
            qpp_pkg::REQ_MOVE:
            begin
                target_next = enc_reg[0] + CW'(s1_req_reg.target_offset);
            end
            qpp_pkg::REQ_TICK:
            begin
                integral_next = integ_sat;
                last_err_next = err;
            end
            default:
            begin
                // The unused code leaves the state alone.
            end
        endcase
    end

    // Gain products, one multiplier per term.
    always_comb
    begin
        s3_prod_p_next = $signed({1'b0, gain_p_reg}) * s2_err_reg;
        s3_prod_i_next = $signed({1'b0, gain_i_reg}) * s2_integ_reg;
        s3_prod_d_next = $signed({1'b0, gain_d_reg}) * s2_deriv_reg;
    end

    // Sum, divide by 256 rounding towards zero, and clamp to the drive range.
    always_comb
    begin
        sum        = qpp_pkg::SUM_W'(s3_prod_p_reg) + qpp_pkg::SUM_W'(s3_prod_i_reg) +
                     qpp_pkg::SUM_W'(s3_prod_d_reg);
        quot_floor = sum >>> qpp_pkg::FRAC_BITS;
        round_up   = sum[qpp_pkg::SUM_W-1] && (|sum[qpp_pkg::FRAC_BITS-1:0]);
        quot       = quot_floor + qpp_pkg::SUM_W'(round_up);
        if (quot > DRIVE_HI)
        begin
            drive_clamped = qpp_pkg::DRIVE_W'(qpp_pkg::DRIVE_LIMIT);
        end
        else if (quot < DRIVE_LO)
        begin
            drive_clamped = -qpp_pkg::DRIVE_W'(qpp_pkg::DRIVE_LIMIT);
        end
        else
        begin
            drive_clamped = quot[qpp_pkg::DRIVE_W-1:0];
        end

        last_drive_next      = s3_tick_reg ? drive_clamped : last_drive_reg;
        rsp_next.drive       = last_drive_next;
        rsp_next.drive_valid = s3_tick_reg;
        rsp_next.position    = qpp_pkg::POS_W'(s3_pos_reg);
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= qpp_pkg::GAIN_P_RESET;
            gain_i_reg <= qpp_pkg::GAIN_I_RESET;
            gain_d_reg <= qpp_pkg::GAIN_D_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qpp_pkg::CFG_GAIN_P: gain_p_reg <= cfg_data;
                qpp_pkg::CFG_GAIN_I: gain_i_reg <= cfg_data;
                qpp_pkg::CFG_GAIN_D: gain_d_reg <= cfg_data;
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Controller state and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < qpp_pkg::NUM_MOTORS; m++)
            begin
                enc_reg[m] <= '0;
            end
            target_reg     <= '0;
            integral_reg   <= '0;
            last_err_reg   <= '0;
            last_drive_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                for (int m = 0; m < qpp_pkg::NUM_MOTORS; m++)
                begin
                    enc_reg[m] <= enc_next[m];
                end
                target_reg   <= target_next;
                integral_reg <= integral_next;
                last_err_reg <= last_err_next;
            end
            if (s3_valid_reg && out_free)
            begin
                last_drive_reg <= last_drive_next;
            end
            if (s1_free)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                rsp_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_free && req_valid)
        begin
            s1_req_reg <= req;
        end
        if (s1_move)
        begin
            s2_tick_reg  <= (s1_req_reg.req_type == qpp_pkg::REQ_TICK);
            s2_pos_reg   <= enc_next[0];
            s2_err_reg   <= err;
            s2_integ_reg <= integ_sat;
            s2_deriv_reg <= deriv;
        end
        if (s2_valid_reg && s3_free)
        begin
            s3_tick_reg   <= s2_tick_reg;
            s3_pos_reg    <= s2_pos_reg;
            s3_prod_p_reg <= s3_prod_p_next;
            s3_prod_i_reg <= s3_prod_i_next;
            s3_prod_d_reg <= s3_prod_d_next;
        end
        if (s3_valid_reg && out_free)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/qpp_checker.sv */
// ---------------------------------------------------------------------------
// qpp_checker
// Port-level checks of the quadrature position controller, bound to its top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quadrature_position_pid_assert.svh"

module qpp_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                req_stall,
    input wire                rsp_valid,
    input wire                rsp_stall,
    input wire qpp_pkg::rsp_t rsp
);

    logic rsp_take;
    logic plain_take;
    logic drive_in_range;

    assign rsp_take       = rsp_valid && !rsp_stall;
    assign plain_take     = rsp_take && !rsp.drive_valid;
    assign drive_in_range = (rsp.drive <= qpp_pkg::DRIVE_LIMIT) &&
                            (rsp.drive >= -qpp_pkg::DRIVE_LIMIT);

    // A held response beat keeps its contents.
    `QPP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // The drive never leaves the symmetric limit.
    `QPP_ASSERT_SAME(a_drive_range, rsp_valid, drive_in_range)

    // Back-to-back beats without a tick must carry the same drive.
    `QPP_ASSERT_SAME(a_drive_repeat, plain_take ##1 plain_take, rsp.drive == $past(rsp.drive))

    // With the output register empty the whole pipeline can move.
    `QPP_ASSERT_SAME(a_no_stall_when_empty, !rsp_valid, !req_stall)

endmodule

bind quadrature_position_pid qpp_checker u_qpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

/* sim/quadrature_position_pid_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_position_pid_tb
// Self-checking bench for the quadrature counters and the PID position loop.
// Request beats are driven through the valid/stall channel while a bit-exact
// model of the counters, the target and the PID step in this file predicts
// every response beat. Each response is checked field by field, in order.
// Gains are changed between phases, only once every response is back.
// ---------------------------------------------------------------------------

module quadrature_position_pid_tb;

    // Clocking and run length. The limit is several times the longest clean
    // run, even with every gap and every stall at its longest.
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int RUN_LIMIT     = 20_000_000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 120;
    localparam int REPORT_LIMIT  = 100;
    localparam int WINDUP_TICKS  = 60;

    // Codes that the package leaves unnamed: the spare request type and the
    // spare register index. Both must be accepted and change nothing.
    localparam logic [1:0]                      REQ_UNUSED = 2'd3;
    localparam logic [qpp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = qpp_pkg::CFG_INDEX_W'(3);

    localparam logic signed [qpp_pkg::OFFSET_W-1:0] OFFSET_MAX =
        {1'b0, {(qpp_pkg::OFFSET_W-1){1'b1}}};
    localparam logic signed [qpp_pkg::OFFSET_W-1:0] OFFSET_MIN =
        {1'b1, {(qpp_pkg::OFFSET_W-1){1'b0}}};
    localparam logic [qpp_pkg::GAIN_W-1:0]          GAIN_MAX   = '1;

    localparam longint INTEGRAL_MAX = (longint'(1) <<< (qpp_pkg::INTEGRAL_WIDTH - 1)) - 1;
    localparam longint INTEGRAL_MIN = -INTEGRAL_MAX - 1;

    // Every input of the block starts at a known value.
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    qpp_pkg::req_t                   req       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    qpp_pkg::rsp_t                   rsp;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [qpp_pkg::CFG_INDEX_W-1:0] cfg_index = qpp_pkg::CFG_GAIN_P;
    logic [qpp_pkg::GAIN_W-1:0]      cfg_data  = '0;

    // Controller state as this bench believes it to be, advanced once per
    // accepted request beat.
    logic [qpp_pkg::COUNT_WIDTH-1:0]           model_count [qpp_pkg::NUM_MOTORS];
    logic [qpp_pkg::COUNT_WIDTH-1:0]           model_target;
    logic signed [qpp_pkg::INTEGRAL_WIDTH-1:0] model_integral;
    logic signed [qpp_pkg::ERR_W-1:0]          model_last_error;
    logic signed [qpp_pkg::DRIVE_W-1:0]        model_last_drive;
    logic [qpp_pkg::GAIN_W-1:0]                gain_p;
    logic [qpp_pkg::GAIN_W-1:0]                gain_i;
    logic [qpp_pkg::GAIN_W-1:0]                gain_d;

    // Response beats still owed by the block, oldest first.
    qpp_pkg::rsp_t expected_beats [$];
    int            mismatch_count = 0;

    // Idling controls. The sender and receiver each insert random gaps when
    // their flag is set; a hold request makes the receiver stall for a long
    // stretch, counted in its own process below.
    bit sender_idling = 1'b0;
    bit rsp_idling    = 1'b0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int stall_left    = 0;

    quadrature_position_pid DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Mostly short gaps, with the odd long one.
    function automatic int pause_length();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    function automatic qpp_pkg::req_t make_request(
        input logic [1:0] kind, input logic [1:0] motor,
        input logic channel, input logic a, input logic b,
        input logic signed [qpp_pkg::OFFSET_W-1:0] offset);
        qpp_pkg::req_t item;
        item.req_type      = kind;
        item.motor_index   = motor;
        item.edge_channel  = channel;
        item.level_a       = a;
        item.level_b       = b;
        item.target_offset = offset;
        return item;
    endfunction

    // One step of the controller. An edge moves one counter, a move command
    // sets the target relative to motor 0, and a tick runs the PID step on
    // exact (unwrapped) error with a saturating integrator. Every beat yields
    // one response: the last drive, whether it is fresh, and motor 0's count.
    task automatic advance_controller(input qpp_pkg::req_t item);
        logic          step_up;
        longint        err;
        longint        integ;
        longint        deriv;
        longint        total;
        longint        level;
        qpp_pkg::rsp_t beat;
        case (item.req_type)
            qpp_pkg::REQ_EDGE:
            begin
                // Channel A counts up when the levels agree, channel B when
                // they differ. Counters wrap at their width.
                step_up = item.edge_channel ? (item.level_a != item.level_b)
                                            : (item.level_a == item.level_b);
                if (int'(item.motor_index) < qpp_pkg::NUM_MOTORS)
                    model_count[item.motor_index] = step_up
                        ? model_count[item.motor_index] + 1'b1
                        : model_count[item.motor_index] - 1'b1;
            end
            qpp_pkg::REQ_MOVE:
                model_target = model_count[0] + item.target_offset;
            qpp_pkg::REQ_TICK:
            begin
                err   = longint'($signed(model_target)) - longint'($signed(model_count[0]));
                integ = longint'(model_integral) + err;
                if (integ > INTEGRAL_MAX)
                    integ = INTEGRAL_MAX;
                if (integ < INTEGRAL_MIN)
                    integ = INTEGRAL_MIN;
                deriv = err - longint'(model_last_error);
                total = longint'(gain_p) * err + longint'(gain_i) * integ
                      + longint'(gain_d) * deriv;
                // Division rounds toward zero, unlike an arithmetic shift.
                level = total / (longint'(1) << qpp_pkg::FRAC_BITS);
                if (level > qpp_pkg::DRIVE_LIMIT)
                    level = qpp_pkg::DRIVE_LIMIT;
                if (level < -qpp_pkg::DRIVE_LIMIT)
                    level = -qpp_pkg::DRIVE_LIMIT;
                model_integral   = qpp_pkg::INTEGRAL_WIDTH'(integ);
                model_last_error = qpp_pkg::ERR_W'(err);
                model_last_drive = qpp_pkg::DRIVE_W'(level);
            end
            default:
                ;
        endcase
        beat.drive       = model_last_drive;
        beat.drive_valid = (item.req_type == qpp_pkg::REQ_TICK);
        beat.position    = model_count[0];
        expected_beats.push_back(beat);
    endtask

    // Offers one request beat and returns at the edge that takes it. Valid is
    // left high, so back-to-back calls keep the channel full; a pause or a
    // drain lowers it.
    task automatic send_request(input qpp_pkg::req_t item);
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        advance_controller(item);
    endtask

    task automatic maybe_pause();
        if (sender_idling && $urandom_range(0, 2) == 0)
        begin
            req_valid <= 1'b0;
            repeat (pause_length()) @(posedge clk);
        end
    endtask

    // Stops sending and waits for every owed response. Always waits on the
    // clock before returning, so valid is never lowered and raised in one step.
    task automatic wait_for_responses();
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (expected_beats.size() != 0 && waited < DRAIN_LIMIT);
        if (expected_beats.size() != 0)
            flag_mismatch($sformatf("%0d expected response beats never arrived",
                                    expected_beats.size()));
    endtask

    task automatic write_gain(input logic [qpp_pkg::CFG_INDEX_W-1:0] index,
                              input logic [qpp_pkg::GAIN_W-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (index)
            qpp_pkg::CFG_GAIN_P: gain_p = value;
            qpp_pkg::CFG_GAIN_I: gain_i = value;
            qpp_pkg::CFG_GAIN_D: gain_d = value;
            default:             ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic. Edges dominate, over half of them on motor 0 so that the
    // loop sees its position move; move offsets are mostly modest so the
    // drive does not sit at its limit all the time.
    function automatic qpp_pkg::req_t random_request();
        qpp_pkg::req_t item;
        int            pick;
        item = $bits(qpp_pkg::req_t)'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            item.req_type = qpp_pkg::REQ_EDGE;
            if ($urandom_range(0, 1) == 0)
                item.motor_index = 2'd0;
        end
        else if (pick < 77)
            item.req_type = qpp_pkg::REQ_TICK;
        else if (pick < 94)
        begin
            item.req_type = qpp_pkg::REQ_MOVE;
            case ($urandom_range(0, 9))
                0:       ;
                1:       item.target_offset = $urandom_range(0, 1) ? OFFSET_MAX : OFFSET_MIN;
                default: item.target_offset =
                             qpp_pkg::OFFSET_W'($urandom_range(0, 512) - 256);
            endcase
        end
        else
            item.req_type = REQ_UNUSED;
        return item;
    endfunction

    task automatic run_phase(input logic [qpp_pkg::GAIN_W-1:0] gp,
                             input logic [qpp_pkg::GAIN_W-1:0] gi,
                             input logic [qpp_pkg::GAIN_W-1:0] gd, input bit with_idling,
                             input int count);
        int            sent;
        qpp_pkg::req_t item;
        wait_for_responses();
        write_gain(qpp_pkg::CFG_GAIN_P, gp);
        write_gain(qpp_pkg::CFG_GAIN_I, gi);
        write_gain(qpp_pkg::CFG_GAIN_D, gd);
        sender_idling = with_idling;
        rsp_idling    = with_idling;
        sent = 0;
        // Beats of the spare request type are sent but not counted.
        while (sent < count)
        begin
            item = random_request();
            send_request(item);
            if (item.req_type != REQ_UNUSED)
                sent++;
            maybe_pause();
        end
    endtask

    // Straight after reset the loop is at rest: a tick must give zero drive,
    // and the spare request type must leave everything untouched.
    task automatic test_reset_state();
        send_request(make_request(qpp_pkg::REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0, '0));
        send_request(make_request(REQ_UNUSED, 2'd3, 1'b1, 1'b1, 1'b1, OFFSET_MIN));
    endtask

    // Every channel and level combination on motor 0, starting with a step
    // down so that the counter wraps below zero, then one edge on each of
    // the other motors, which must not disturb the reported position.
    task automatic test_encoder_counting();
        logic [2:0] combo;
        for (int k = 7; k >= 0; k--)
        begin
            combo = 3'(k);
            send_request(make_request(qpp_pkg::REQ_EDGE, 2'd0, combo[2], combo[1],
                                      combo[0], '0));
        end
        for (int m = 1; m < qpp_pkg::NUM_MOTORS; m++)
            send_request(make_request(qpp_pkg::REQ_EDGE, 2'(m), 1'($urandom),
                                      1'($urandom), 1'($urandom),
                                      qpp_pkg::OFFSET_W'($urandom)));
    endtask

    // Extreme move offsets drive the output into both limits; a move from a
    // negative count with the most negative offset wraps the target round.
    task automatic test_move_and_drive();
        qpp_pkg::req_t tick;
        tick = make_request(qpp_pkg::REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0, '0);
        send_request(make_request(qpp_pkg::REQ_MOVE, 2'd0, 1'b0, 1'b0, 1'b0, OFFSET_MAX));
        send_request(tick);
        send_request(tick);
        send_request(make_request(qpp_pkg::REQ_MOVE, 2'd0, 1'b0, 1'b0, 1'b0, OFFSET_MIN));
        send_request(tick);
        send_request(make_request(qpp_pkg::REQ_EDGE, 2'd0, 1'b0, 1'b1, 1'b0, '0));
        send_request(make_request(qpp_pkg::REQ_MOVE, 2'd0, 1'b0, 1'b0, 1'b0, OFFSET_MIN));
        send_request(tick);
        send_request(tick);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats back to back, so the pipeline fills and req_stall must
    // rise. The sender then waits until every response has come back.
    task automatic test_backpressure();
        wait_for_responses();
        sender_idling = 1'b0;
        rsp_idling    = 1'b1;
        hold_request  = 1'b1;
        repeat (40) send_request(random_request());
        wait_for_responses();
    endtask

    // Runs of ticks at a large error of either sign wind the integrator up
    // one way and then back the other, with the drive pinned at its limits.
    // Run at full rate with no idling.
    task automatic test_integral_windup();
        qpp_pkg::req_t tick;
        tick = make_request(qpp_pkg::REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0, '0);
        wait_for_responses();
        sender_idling = 1'b0;
        rsp_idling    = 1'b0;
        send_request(make_request(qpp_pkg::REQ_MOVE, 2'd0, 1'b0, 1'b0, 1'b0,
            qpp_pkg::OFFSET_W'(longint'(OFFSET_MIN) - longint'($signed(model_count[0])))));
        repeat (WINDUP_TICKS) send_request(tick);
        send_request(make_request(qpp_pkg::REQ_MOVE, 2'd0, 1'b0, 1'b0, 1'b0,
            qpp_pkg::OFFSET_W'(longint'(OFFSET_MAX) - longint'($signed(model_count[0])))));
        repeat (WINDUP_TICKS) send_request(tick);
    endtask

    // Several gain settings, the extremes among them, with one phase free of
    // idling on both sides. A write to the spare register index must have no
    // effect on the gains that follow it.
    task automatic test_random_traffic();
        run_phase(qpp_pkg::GAIN_P_RESET, qpp_pkg::GAIN_I_RESET, qpp_pkg::GAIN_D_RESET,
                  1'b1, 250);
        run_phase('0, '0, '0, 1'b1, 150);
        run_phase(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b0, 250);
        wait_for_responses();
        write_gain(CFG_UNUSED, qpp_pkg::GAIN_W'($urandom));
        run_phase(qpp_pkg::GAIN_W'($urandom), qpp_pkg::GAIN_W'($urandom),
                  qpp_pkg::GAIN_W'($urandom), 1'b1, 250);
        run_phase(qpp_pkg::GAIN_W'($urandom_range(0, 512)),
                  qpp_pkg::GAIN_W'($urandom_range(0, 512)),
                  qpp_pkg::GAIN_W'($urandom_range(0, 512)), 1'b1, 250);
    endtask

    // Receiver stall. A long hold takes priority; otherwise, when idling is
    // enabled, random stalls of mixed length are inserted.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (!rsp_idling)
            rsp_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = pause_length() - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    // Response checker. Values are sampled at the edge itself, before any
    // of this edge's updates land, so they are the ones the block saw.
    always @(posedge clk)
    begin
        qpp_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_beats.size() == 0)
                flag_mismatch($sformatf("stray response: drive %0d valid %0b position %0d",
                                        rsp.drive, rsp.drive_valid, rsp.position));
            else
            begin
                want = expected_beats.pop_front();
                if (rsp.drive !== want.drive)
                    flag_mismatch($sformatf("drive %0d, expected %0d",
                                            rsp.drive, want.drive));
                if (rsp.drive_valid !== want.drive_valid)
                    flag_mismatch($sformatf("drive_valid %0b, expected %0b",
                                            rsp.drive_valid, want.drive_valid));
                if (rsp.position !== want.position)
                    flag_mismatch($sformatf("position %0d, expected %0d",
                                            rsp.position, want.position));
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("quadrature_position_pid_tb: errors");
        $finish;
    end

    initial
    begin
        for (int m = 0; m < qpp_pkg::NUM_MOTORS; m++)
            model_count[m] = '0;
        model_target     = '0;
        model_integral   = '0;
        model_last_error = '0;
        model_last_drive = '0;
        gain_p           = qpp_pkg::GAIN_P_RESET;
        gain_i           = qpp_pkg::GAIN_I_RESET;
        gain_d           = qpp_pkg::GAIN_D_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idling = 1'b1;
        rsp_idling    = 1'b1;
        test_reset_state();
        test_encoder_counting();
        test_move_and_drive();
        test_backpressure();
        test_integral_windup();
        test_random_traffic();

        // Everything sent: collect the last responses, then give the block a
        // few more cycles in case it produces a stray beat.
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("quadrature_position_pid_tb: clean");
        else
            $display("quadrature_position_pid_tb: errors");
        $finish;
    end

endmodule
